[hdl/rtp_pkg.sv]
package rtp_pkg;

    localparam int IN_WIDTH_DEF = 16;
    localparam int STAGES_DEF   = 16;

    localparam int GUARD_BITS = 8;
    localparam int ZW         = 26;
    localparam int ANG_W      = ZW - GUARD_BITS;

    localparam logic signed [ZW-1:0] QUARTER_UNITS = ZW'(90 * 32768);
    localparam logic signed [ZW-1:0] HALF_UNITS    = ZW'(180 * 32768);
    localparam logic signed [ZW-1:0] THREEQ_UNITS  = ZW'(270 * 32768);
    localparam logic signed [ZW-1:0] TURN_UNITS    = ZW'(360 * 32768);
    localparam logic signed [ZW-1:0] ROUND_UNITS   = ZW'(128);
    localparam logic [ANG_W-1:0]     OUT_TURN      = ANG_W'(46080);

    typedef enum logic [2:0] {
        AXIS_NONE,
        AXIS_ZERO,
        AXIS_90,
        AXIS_180,
        AXIS_270
    } axis_t;

    // round(atan(2^-i) * 180/pi * 32768)
    function automatic logic signed [ZW-1:0] atan_units(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = ZW'(1474560);
            1:       v = ZW'(870484);
            2:       v = ZW'(459940);
            3:       v = ZW'(233473);
            4:       v = ZW'(117189);
            5:       v = ZW'(58652);
            6:       v = ZW'(29333);
            7:       v = ZW'(14667);
            8:       v = ZW'(7334);
            9:       v = ZW'(3667);
            10:      v = ZW'(1833);
            11:      v = ZW'(917);
            12:      v = ZW'(458);
            13:      v = ZW'(229);
            14:      v = ZW'(115);
            15:      v = ZW'(57);
            16:      v = ZW'(29);
            17:      v = ZW'(14);
            18:      v = ZW'(7);
            19:      v = ZW'(4);
            20:      v = ZW'(2);
            21:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/rtp_front.sv]
module rtp_front
    import rtp_pkg::*;
#(
    parameter int W  = IN_WIDTH_DEF,
    parameter int XW = IN_WIDTH_DEF + 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic [W-1:0]           up_re,
    input  logic [W-1:0]           up_im,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output logic signed [XW-1:0]   dn_x,
    output logic signed [XW-1:0]   dn_y,
    output logic signed [ZW-1:0]   dn_z,
    output axis_t                  dn_axis,
    output logic [2*W-1:0]         dn_n
);

    localparam int SW = 2 * W;

    logic                 a_valid_reg, b_valid_reg, c_valid_reg;
    logic                 a_ready, b_ready, c_ready;
    logic signed [XW-1:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg, c_x_reg, c_y_reg;
    logic signed [ZW-1:0] a_z_reg, b_z_reg, c_z_reg;
    axis_t                a_axis_reg, b_axis_reg, c_axis_reg;
    logic [W-1:0]         a_are_reg, a_aim_reg;
    logic [SW-1:0]        b_sqre_reg, b_sqim_reg, c_n_reg;

    logic signed [XW-1:0] re_x, im_x, x_next, y_next;
    logic signed [ZW-1:0] z_next;
    logic [W-1:0]         are_next, aim_next;
    logic                 re_neg, im_neg, re_zero, im_zero;
    axis_t                axis_next;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign c_ready  = !c_valid_reg || dn_ready;
    assign up_ready = a_ready;

    always_comb
    begin
        re_neg  = up_re[W-1];
        im_neg  = up_im[W-1];
        re_zero = (up_re == '0);
        im_zero = (up_im == '0);
        re_x    = XW'(signed'(up_re));
        im_x    = XW'(signed'(up_im));
        // fold the left half plane onto the right one
        x_next  = (re_neg ? -re_x : re_x) <<< GUARD_BITS;
        y_next  = (re_neg ? -im_x : im_x) <<< GUARD_BITS;
        z_next  = re_neg ? HALF_UNITS : '0;
        are_next = re_neg ? W'(-up_re) : up_re;
        aim_next = im_neg ? W'(-up_im) : up_im;
        if (re_zero && im_zero)
            axis_next = AXIS_ZERO;
        else if (im_zero)
            axis_next = re_neg ? AXIS_180 : AXIS_ZERO;
        else if (re_zero)
            axis_next = im_neg ? AXIS_270 : AXIS_90;
        else
            axis_next = AXIS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= up_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_x_reg    <= x_next;
            a_y_reg    <= y_next;
            a_z_reg    <= z_next;
            a_axis_reg <= axis_next;
            a_are_reg  <= are_next;
            a_aim_reg  <= aim_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_z_reg    <= a_z_reg;
            b_axis_reg <= a_axis_reg;
            b_sqre_reg <= SW'(a_are_reg) * SW'(a_are_reg);
            b_sqim_reg <= SW'(a_aim_reg) * SW'(a_aim_reg);
        end
        if (c_ready && b_valid_reg)
        begin
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
            c_z_reg    <= b_z_reg;
            c_axis_reg <= b_axis_reg;
            c_n_reg    <= b_sqre_reg + b_sqim_reg;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_x     = c_x_reg;
    assign dn_y     = c_y_reg;
    assign dn_z     = c_z_reg;
    assign dn_axis  = c_axis_reg;
    assign dn_n     = c_n_reg;

endmodule

[hdl/rtp_step.sv]
module rtp_step
    import rtp_pkg::*;
#(
    parameter int W      = IN_WIDTH_DEF,
    parameter int XW     = IN_WIDTH_DEF + 11,
    parameter int IDX    = 0,
    parameter int STAGES = STAGES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic signed [XW-1:0]   up_x,
    input  logic signed [XW-1:0]   up_y,
    input  logic signed [ZW-1:0]   up_z,
    input  axis_t                  up_axis,
    input  logic [2*W-1:0]         up_rem,
    input  logic [2*W:0]           up_res,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output logic signed [XW-1:0]   dn_x,
    output logic signed [XW-1:0]   dn_y,
    output logic signed [ZW-1:0]   dn_z,
    output axis_t                  dn_axis,
    output logic [2*W-1:0]         dn_rem,
    output logic [2*W:0]           dn_res
);

    localparam int SW        = 2 * W;
    localparam int RW        = 2 * W + 1;
    localparam bit CORDIC_ON = (IDX < STAGES);
    localparam bit SQRT_ON   = (IDX < W);
    localparam int SHAMT     = SQRT_ON ? 2 * (W - 1 - IDX) : 0;
    localparam logic [RW-1:0] SQ_BIT = SQRT_ON ? (RW'(1) << SHAMT) : '0;
    localparam logic signed [ZW-1:0] ATAN = atan_units(IDX);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;
    axis_t                axis_reg;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [RW-1:0]        res_reg, res_next, trial;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        xs = up_x >>> IDX;
        ys = up_y >>> IDX;
        x_next = up_x;
        y_next = up_y;
        z_next = up_z;
        if (CORDIC_ON)
        begin
            if (!up_y[XW-1])
            begin
                x_next = up_x + ys;
                y_next = up_y - xs;
                z_next = up_z + ATAN;
            end
            else
            begin
                x_next = up_x - ys;
                y_next = up_y + xs;
                z_next = up_z - ATAN;
            end
        end
    end

    always_comb
    begin
        trial    = up_res + SQ_BIT;
        rem_next = up_rem;
        res_next = up_res;
        if (SQRT_ON)
        begin
            if ({1'b0, up_rem} >= trial)
            begin
                rem_next = up_rem - trial[SW-1:0];
                res_next = (up_res >> 1) + SQ_BIT;
            end
            else
            begin
                res_next = up_res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            axis_reg <= up_axis;
            rem_reg  <= rem_next;
            res_reg  <= res_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;
    assign dn_axis  = axis_reg;
    assign dn_rem   = rem_reg;
    assign dn_res   = res_reg;

endmodule

[hdl/rtp_back.sv]
module rtp_back
    import rtp_pkg::*;
#(
    parameter int W = IN_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic signed [ZW-1:0]   up_z,
    input  axis_t                  up_axis,
    input  logic [2*W-1:0]         up_rem,
    input  logic [2*W:0]           up_res,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output logic [15:0]            dn_modulus,
    output logic [15:0]            dn_angle
);

    localparam int RW = 2 * W + 1;

    logic                 valid_reg;
    logic [15:0]          modulus_reg, modulus_next, angle_reg, angle_next;
    logic signed [ZW-1:0] z_sel, z_fold, z_round;
    logic [ANG_W-1:0]     ang;
    logic [RW-1:0]        res_round;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        case (up_axis)
            AXIS_ZERO: z_sel = '0;
            AXIS_90:   z_sel = QUARTER_UNITS;
            AXIS_180:  z_sel = HALF_UNITS;
            AXIS_270:  z_sel = THREEQ_UNITS;
            default:   z_sel = up_z;
        endcase
        z_fold  = z_sel[ZW-1] ? z_sel + TURN_UNITS : z_sel;
        z_round = z_fold + ROUND_UNITS;
        ang     = z_round[ZW-1:GUARD_BITS];
        if (ang >= OUT_TURN)
            ang = ang - OUT_TURN;
        angle_next = ang[15:0];

        // round to nearest: bump when the remainder exceeds the root
        res_round = up_res + RW'({1'b0, up_rem} > up_res);
        if (|res_round[RW-1:16])
            modulus_next = 16'hFFFF;
        else
            modulus_next = res_round[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            modulus_reg <= modulus_next;
            angle_reg   <= angle_next;
        end
    end

    assign dn_valid   = valid_reg;
    assign dn_modulus = modulus_reg;
    assign dn_angle   = angle_reg;

endmodule

[hdl/rect_to_polar_degrees_unit.sv]
// throughput: one request per cycle while the output accepts results; the cordic
// micro-rotations and the square-root digits share one register stage per step,
// three front stages (fold, square, sum) and one rounding stage; a stall holds each
// stage until the next one frees up
// reset: rst_n clears all valid bits asynchronously, the pipeline comes up empty
module rect_to_polar_degrees_unit
    import rtp_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF,
    parameter int STAGES   = STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  logic [IN_WIDTH-1:0] real_part,
    input  logic [IN_WIDTH-1:0] imag_part,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [15:0]         modulus,
    output logic [15:0]         angle_deg
);

    localparam int W     = IN_WIDTH;
    localparam int XW    = IN_WIDTH + 11;
    localparam int NSTEP = (STAGES > IN_WIDTH) ? STAGES : IN_WIDTH;

    logic                 s_valid [0:NSTEP];
    logic                 s_ready [0:NSTEP];
    logic signed [XW-1:0] s_x     [0:NSTEP];
    logic signed [XW-1:0] s_y     [0:NSTEP];
    logic signed [ZW-1:0] s_z     [0:NSTEP];
    axis_t                s_axis  [0:NSTEP];
    logic [2*W-1:0]       s_rem   [0:NSTEP];
    logic [2*W:0]         s_res   [0:NSTEP];

    rtp_front #(
        .W  (W),
        .XW (XW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sample_valid),
        .up_ready (sample_ready),
        .up_re    (real_part),
        .up_im    (imag_part),
        .dn_valid (s_valid[0]),
        .dn_ready (s_ready[0]),
        .dn_x     (s_x[0]),
        .dn_y     (s_y[0]),
        .dn_z     (s_z[0]),
        .dn_axis  (s_axis[0]),
        .dn_n     (s_rem[0])
    );

    assign s_res[0] = '0;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        rtp_step #(
            .W      (W),
            .XW     (XW),
            .IDX    (i),
            .STAGES (STAGES)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (s_valid[i]),
            .up_ready (s_ready[i]),
            .up_x     (s_x[i]),
            .up_y     (s_y[i]),
            .up_z     (s_z[i]),
            .up_axis  (s_axis[i]),
            .up_rem   (s_rem[i]),
            .up_res   (s_res[i]),
            .dn_valid (s_valid[i+1]),
            .dn_ready (s_ready[i+1]),
            .dn_x     (s_x[i+1]),
            .dn_y     (s_y[i+1]),
            .dn_z     (s_z[i+1]),
            .dn_axis  (s_axis[i+1]),
            .dn_rem   (s_rem[i+1]),
            .dn_res   (s_res[i+1])
        );
    end

    rtp_back #(
        .W (W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s_valid[NSTEP]),
        .up_ready   (s_ready[NSTEP]),
        .up_z       (s_z[NSTEP]),
        .up_axis    (s_axis[NSTEP]),
        .up_rem     (s_rem[NSTEP]),
        .up_res     (s_res[NSTEP]),
        .dn_valid   (result_valid),
        .dn_ready   (result_ready),
        .dn_modulus (modulus),
        .dn_angle   (angle_deg)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int  IN_W        = 16;
    localparam int  ROTATIONS   = 16;
    localparam int  DRAIN_WAIT  = 40;
    localparam int  HOLD_CYCLES = 300;
    localparam int  CYCLE_LIMIT = 200000;
    localparam longint DEG      = 32768;
    localparam longint FULL_TURN_Z = 360 * DEG;
    localparam longint HALF_TURN_Z = 180 * DEG;
    localparam longint Q1_Z        = 90 * DEG;
    localparam longint Q3_Z        = 270 * DEG;
    localparam longint ANGLE_WRAP  = 46080;

    // atan(2^-i) in 1/32768 degree
    localparam longint ATAN_Z [0:15] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57
    };

    typedef struct packed {
        logic [15:0] modulus;
        logic [15:0] angle;
    } polar_t;

    logic                clk;
    logic                rst_n;
    logic                sample_valid;
    logic                sample_ready;
    logic [IN_W-1:0]     real_part;
    logic [IN_W-1:0]     imag_part;
    logic                result_valid;
    logic                result_ready;
    logic [15:0]         modulus;
    logic [15:0]         angle_deg;

    polar_t pending_polar [$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     steady         = 0;
    bit     hold_request   = 0;

    rect_to_polar_degrees_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .real_part    (real_part),
        .imag_part    (imag_part),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .modulus      (modulus),
        .angle_deg    (angle_deg)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic polar_t predict_polar(logic signed [IN_W-1:0] re_in,
                                             logic signed [IN_W-1:0] im_in);
        longint re, im, sq, root, cand, x, y, z, xs, ys, ang;
        polar_t p;
        re = re_in;
        im = im_in;
        sq = re * re + im * im;
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= sq)
                root = cand;
        end
        if (sq - root * root > root)
            root++;
        if (root > 65535)
            root = 65535;

        if (re == 0 && im == 0)
            z = 0;
        else if (im == 0)
            z = (re < 0) ? HALF_TURN_Z : 0;
        else if (re == 0)
            z = (im > 0) ? Q1_Z : Q3_Z;
        else
        begin
            x = re * 256;
            y = im * 256;
            z = 0;
            // fold the left half plane onto the right
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF_TURN_Z;
            end
            for (int i = 0; i < ROTATIONS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Z[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Z[i];
                end
            end
        end
        if (z < 0)
            z = z + FULL_TURN_Z;
        ang = (z + 128) >>> 8;
        if (ang >= ANGLE_WRAP)
            ang = ang - ANGLE_WRAP;
        p.modulus = root[15:0];
        p.angle   = ang[15:0];
        return p;
    endfunction

    task automatic send_sample(logic signed [IN_W-1:0] re, logic signed [IN_W-1:0] im);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 9)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        real_part    <= re;
        imag_part    <= im;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_polar.push_back(predict_polar(re, im));
    endtask

    // response side: random stalls (always ready while steady), or one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 0;
            end
            else
                result_ready <= steady ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        polar_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_polar.size() == 0)
            begin
                $error("result with no request outstanding: modulus %0d angle %0d",
                       modulus, angle_deg);
                mismatch_count++;
            end
            else
            begin
                want = pending_polar.pop_front();
                if (modulus !== want.modulus)
                begin
                    $error("modulus expected %0d actual %0d", want.modulus, modulus);
                    mismatch_count++;
                end
                if (angle_deg !== want.angle)
                begin
                    $error("angle_deg expected %0d actual %0d", want.angle, angle_deg);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_axes_and_corners();
        send_sample(0, 0);
        send_sample(1, 0);
        send_sample(-1, 0);
        send_sample(0, 1);
        send_sample(0, -1);
        send_sample(32767, 0);
        send_sample(-32768, 0);
        send_sample(0, 32767);
        send_sample(0, -32768);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(1, 1);
        send_sample(-1, -1);
        send_sample(1, -1);
        send_sample(-1, 1);
        // tiny negative angles that round up to a full turn, and angles just off 180 degrees
        send_sample(32767, -1);
        send_sample(20000, -1);
        send_sample(-32768, 1);
        send_sample(-32768, -1);
        send_sample(3, 4);
        send_sample(-5, 12);
    endtask

    task automatic test_random_full_range(int count);
        steady = 1;
        for (int n = 0; n < count; n++)
        begin
            if (n == 200)
                steady = 0;
            send_sample(IN_W'($urandom), IN_W'($urandom));
        end
    endtask

    task automatic test_random_small(int count);
        for (int n = 0; n < count; n++)
            send_sample(IN_W'($urandom_range(16) - 8), IN_W'($urandom_range(16) - 8));
    endtask

    task automatic test_random_near_axes(int count);
        logic signed [IN_W-1:0] wide, narrow;
        for (int n = 0; n < count; n++)
        begin
            wide   = IN_W'($urandom);
            narrow = IN_W'($urandom_range(6) - 3);
            if ($urandom_range(1))
                send_sample(wide, narrow);
            else
                send_sample(narrow, wide);
        end
    endtask

    task automatic test_output_backpressure(int count);
        hold_request = 1;
        for (int n = 0; n < count; n++)
            send_sample(IN_W'($urandom), IN_W'($urandom));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        real_part    = '0;
        imag_part    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_axes_and_corners();
        test_random_full_range(800);
        test_random_small(300);
        test_random_near_axes(350);
        test_output_backpressure(150);
        test_random_full_range(130);

        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_polar.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
